// ===== rtl/cpu6502_load_store_unit_macros.svh =====
// Assertion macros for the 6502 load/store unit.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef CPU6502_LOAD_STORE_UNIT_MACROS_SVH
`define CPU6502_LOAD_STORE_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define C6502_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define C6502_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/c6502lsu_pkg.sv =====
// Package for the 6502 load/store unit: operation, mode, phase and result codes,
// the result record and the flag helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c6502lsu_pkg;

    localparam logic [7:0] STATUS_ONE = 8'h20;
    localparam logic [7:0] SIGN_BIT   = 8'h80;
    localparam logic [7:0] SP_RESET   = 8'hFD;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 4;
    localparam int FLAG_N = 5;

    typedef enum logic [4:0] {
        OP_LDA = 5'd0,
        OP_LDX = 5'd1,
        OP_LDY = 5'd2,
        OP_STA = 5'd3,
        OP_STX = 5'd4,
        OP_STY = 5'd5,
        OP_TAX = 5'd6,
        OP_TAY = 5'd7,
        OP_TXA = 5'd8,
        OP_TYA = 5'd9,
        OP_TSX = 5'd10,
        OP_TXS = 5'd11,
        OP_SEC = 5'd12,
        OP_CLC = 5'd13,
        OP_SED = 5'd14,
        OP_CLD = 5'd15,
        OP_SEI = 5'd16,
        OP_CLI = 5'd17,
        OP_CLV = 5'd18
    } op_t;

    typedef enum logic [3:0] {
        MODE_IMP = 4'd0,
        MODE_IMM = 4'd1,
        MODE_ZP  = 4'd2,
        MODE_ZPX = 4'd3,
        MODE_ZPY = 4'd4,
        MODE_ABS = 4'd5,
        MODE_ABX = 4'd6,
        MODE_ABY = 4'd7,
        MODE_IZX = 4'd8,
        MODE_IZY = 4'd9
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PTR_LO = 2'd1,
        PH_PTR_HI = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERR   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        page_crossed;
        logic [7:0]  status_byte;
        logic [7:0]  stack_value;
        logic [7:0]  y_value;
        logic [7:0]  x_value;
        logic [7:0]  acc_value;
        logic [7:0]  write_data;
        logic [15:0] bus_addr;
    } result_t;

    function automatic logic [5:0] nz_update(input logic [5:0] flags, input logic [7:0] v);
        logic [5:0] f;
        f = flags;
        f[FLAG_Z] = (v == 8'h00);
        f[FLAG_N] = ((v & SIGN_BIT) != 8'h00);
        return f;
    endfunction

    function automatic logic [7:0] status_pack(input logic [5:0] flags);
        return {flags[FLAG_N], flags[FLAG_V], 2'b00, flags[FLAG_D], flags[FLAG_I],
                flags[FLAG_Z], flags[FLAG_C]} | STATUS_ONE;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cpu6502_load_store_unit.sv =====
// 6502 load/store unit top level: address generation, register file and result buffer.
// Depends on c6502lsu_pkg and cpu6502_load_store_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "cpu6502_load_store_unit_macros.svh"

// Executes 6502 loads, stores, register transfers and flag instructions, one input
// transaction per clock while the skid entry is empty, with exactly one result
// transaction each. Each transaction is decoded, its effective address (zero-page
// wrap, page-crossing detect) formed and the architectural state registered on
// acceptance. Indirect modes take two pointer-read round trips, loads one data
// round trip, all through the same channels. A two-entry result buffer keeps the
// input open for one more transaction while the result side stalls.
module cpu6502_load_store_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // op[4:0], mode[8:5], operand_lo[16:9], operand_hi[24:17], read_data[32:25], zero pad
    input  wire logic [39:0] s_tdata,
    // cmd[0]
    input  wire logic [0:0]  s_tuser,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // bus_addr[15:0], write_data[23:16], acc_value[31:24], x_value[39:32],
    // y_value[47:40], stack_value[55:48], status_byte[63:56], page_crossed[64], zero pad
    output      logic [71:0] m_tdata,
    // kind[1:0]
    output      logic [1:0]  m_tuser
);

    logic                 in_cmd;
    c6502lsu_pkg::op_t    in_op;
    c6502lsu_pkg::mode_t  in_mode;
    logic [7:0]           in_lo;
    logic [7:0]           in_hi;
    logic [7:0]           in_rd;
    logic                 accept;

    logic [7:0]           acc_reg, acc_next;
    logic [7:0]           x_reg, x_next;
    logic [7:0]           y_reg, y_next;
    logic [7:0]           sp_reg, sp_next;
    logic [5:0]           flags_reg, flags_next;
    c6502lsu_pkg::phase_t phase_reg, phase_next;
    c6502lsu_pkg::op_t    pend_op_reg, pend_op_next;
    c6502lsu_pkg::mode_t  pend_mode_reg, pend_mode_next;
    logic [7:0]           ptr_low_reg, ptr_low_next;
    logic [7:0]           zp_ptr_reg, zp_ptr_next;

    c6502lsu_pkg::result_t res;
    c6502lsu_pkg::result_t out_reg;
    c6502lsu_pkg::result_t skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;

    logic                 instr_ok;
    logic                 mode_bad;
    logic                 mem_go;
    logic [7:0]           zpx_addr;
    logic [7:0]           zpy_addr;
    logic [7:0]           zp_ptr_inc;
    logic [15:0]          abs_base;
    logic [15:0]          abx_sum;
    logic [15:0]          aby_sum;
    logic [15:0]          ind_base;
    logic [15:0]          izy_sum;

    logic                 do_access;
    c6502lsu_pkg::op_t    access_op;
    logic [15:0]          access_addr;
    logic                 access_pc;
    logic                 do_load;
    c6502lsu_pkg::op_t    load_op;
    logic [7:0]           load_val;

    logic                 phase_idle;
    logic                 data_back;
    logic                 err_out;

    assign in_cmd  = s_tuser[0];
    assign in_op   = c6502lsu_pkg::op_t'(s_tdata[4:0]);
    assign in_mode = c6502lsu_pkg::mode_t'(s_tdata[8:5]);
    assign in_lo   = s_tdata[16:9];
    assign in_hi   = s_tdata[24:17];
    assign in_rd   = s_tdata[32:25];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign instr_ok = !in_cmd && (phase_reg == c6502lsu_pkg::PH_IDLE)
                      && (in_op <= c6502lsu_pkg::OP_CLV);
    assign mode_bad = (in_mode > c6502lsu_pkg::MODE_IZY) || (in_mode == c6502lsu_pkg::MODE_IMP)
                      || ((in_op >= c6502lsu_pkg::OP_STA) && (in_mode == c6502lsu_pkg::MODE_IMM));
    assign mem_go   = instr_ok && (in_op <= c6502lsu_pkg::OP_STY) && !mode_bad;

    assign zpx_addr   = in_lo + x_reg;
    assign zpy_addr   = in_lo + y_reg;
    assign zp_ptr_inc = zp_ptr_reg + 8'd1;
    assign abs_base   = {in_hi, in_lo};
    assign abx_sum    = abs_base + {8'h00, x_reg};
    assign aby_sum    = abs_base + {8'h00, y_reg};
    assign ind_base   = {in_rd, ptr_low_reg};
    assign izy_sum    = ind_base + {8'h00, y_reg};

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (in_cmd) begin
                case (phase_reg)
                    c6502lsu_pkg::PH_PTR_LO: phase_next = c6502lsu_pkg::PH_PTR_HI;
                    c6502lsu_pkg::PH_PTR_HI: begin
                        phase_next = (pend_op_reg <= c6502lsu_pkg::OP_LDY) ?
                                     c6502lsu_pkg::PH_DATA : c6502lsu_pkg::PH_IDLE;
                    end
                    c6502lsu_pkg::PH_DATA:   phase_next = c6502lsu_pkg::PH_IDLE;
                    default:                 phase_next = phase_reg;
                endcase
            end else if (mem_go) begin
                case (in_mode)
                    c6502lsu_pkg::MODE_IMM: phase_next = c6502lsu_pkg::PH_IDLE;
                    c6502lsu_pkg::MODE_IZX,
                    c6502lsu_pkg::MODE_IZY: phase_next = c6502lsu_pkg::PH_PTR_LO;
                    default: begin
                        phase_next = (in_op <= c6502lsu_pkg::OP_LDY) ?
                                     c6502lsu_pkg::PH_DATA : c6502lsu_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result and register updates
    always_comb begin
        acc_next       = acc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        sp_next        = sp_reg;
        flags_next     = flags_reg;
        pend_op_next   = pend_op_reg;
        pend_mode_next = pend_mode_reg;
        ptr_low_next   = ptr_low_reg;
        zp_ptr_next    = zp_ptr_reg;
        res            = '0;
        res.kind       = c6502lsu_pkg::KIND_ERR;
        do_access      = 1'b0;
        access_op      = pend_op_reg;
        access_addr    = 16'h0000;
        access_pc      = 1'b0;
        do_load        = 1'b0;
        load_op        = pend_op_reg;
        load_val       = in_rd;

        if (accept) begin
            if (in_cmd) begin
                case (phase_reg)
                    c6502lsu_pkg::PH_PTR_LO: begin
                        ptr_low_next = in_rd;
                        res.kind     = c6502lsu_pkg::KIND_READ;
                        res.bus_addr = {8'h00, zp_ptr_inc};
                    end
                    c6502lsu_pkg::PH_PTR_HI: begin
                        do_access = 1'b1;
                        if (pend_mode_reg == c6502lsu_pkg::MODE_IZY) begin
                            access_addr = izy_sum;
                            access_pc   = (izy_sum[15:8] != in_rd);
                        end else begin
                            access_addr = ind_base;
                        end
                    end
                    c6502lsu_pkg::PH_DATA: begin
                        do_load  = 1'b1;
                        res.kind = c6502lsu_pkg::KIND_DONE;
                    end
                    default: res.kind = c6502lsu_pkg::KIND_ERR;
                endcase
            end else if (instr_ok) begin
                if (in_op >= c6502lsu_pkg::OP_TAX) begin
                    res.kind = c6502lsu_pkg::KIND_DONE;
                    case (in_op)
                        c6502lsu_pkg::OP_TAX: begin
                            x_next     = acc_reg;
                            flags_next = c6502lsu_pkg::nz_update(flags_reg, acc_reg);
                        end
                        c6502lsu_pkg::OP_TAY: begin
                            y_next     = acc_reg;
                            flags_next = c6502lsu_pkg::nz_update(flags_reg, acc_reg);
                        end
                        c6502lsu_pkg::OP_TXA: begin
                            acc_next   = x_reg;
                            flags_next = c6502lsu_pkg::nz_update(flags_reg, x_reg);
                        end
                        c6502lsu_pkg::OP_TYA: begin
                            acc_next   = y_reg;
                            flags_next = c6502lsu_pkg::nz_update(flags_reg, y_reg);
                        end
                        c6502lsu_pkg::OP_TSX: begin
                            x_next     = sp_reg;
                            flags_next = c6502lsu_pkg::nz_update(flags_reg, sp_reg);
                        end
                        c6502lsu_pkg::OP_TXS: sp_next = x_reg;
                        c6502lsu_pkg::OP_SEC: flags_next[c6502lsu_pkg::FLAG_C] = 1'b1;
                        c6502lsu_pkg::OP_CLC: flags_next[c6502lsu_pkg::FLAG_C] = 1'b0;
                        c6502lsu_pkg::OP_SED: flags_next[c6502lsu_pkg::FLAG_D] = 1'b1;
                        c6502lsu_pkg::OP_CLD: flags_next[c6502lsu_pkg::FLAG_D] = 1'b0;
                        c6502lsu_pkg::OP_SEI: flags_next[c6502lsu_pkg::FLAG_I] = 1'b1;
                        c6502lsu_pkg::OP_CLI: flags_next[c6502lsu_pkg::FLAG_I] = 1'b0;
                        default:              flags_next[c6502lsu_pkg::FLAG_V] = 1'b0;
                    endcase
                end else if (!mode_bad) begin
                    pend_op_next   = in_op;
                    pend_mode_next = in_mode;
                    access_op      = in_op;
                    load_op        = in_op;
                    case (in_mode)
                        c6502lsu_pkg::MODE_IMM: begin
                            do_load  = 1'b1;
                            load_val = in_lo;
                            res.kind = c6502lsu_pkg::KIND_DONE;
                        end
                        c6502lsu_pkg::MODE_ZP: begin
                            do_access   = 1'b1;
                            access_addr = {8'h00, in_lo};
                        end
                        c6502lsu_pkg::MODE_ZPX: begin
                            do_access   = 1'b1;
                            access_addr = {8'h00, zpx_addr};
                        end
                        c6502lsu_pkg::MODE_ZPY: begin
                            do_access   = 1'b1;
                            access_addr = {8'h00, zpy_addr};
                        end
                        c6502lsu_pkg::MODE_ABS: begin
                            do_access   = 1'b1;
                            access_addr = abs_base;
                        end
                        c6502lsu_pkg::MODE_ABX: begin
                            do_access   = 1'b1;
                            access_addr = abx_sum;
                            access_pc   = (abx_sum[15:8] != in_hi);
                        end
                        c6502lsu_pkg::MODE_ABY: begin
                            do_access   = 1'b1;
                            access_addr = aby_sum;
                            access_pc   = (aby_sum[15:8] != in_hi);
                        end
                        default: begin
                            zp_ptr_next  = (in_mode == c6502lsu_pkg::MODE_IZX) ? zpx_addr : in_lo;
                            res.kind     = c6502lsu_pkg::KIND_READ;
                            res.bus_addr = {8'h00, zp_ptr_next};
                        end
                    endcase
                end
            end
        end

        if (do_access) begin
            res.bus_addr     = access_addr;
            res.page_crossed = access_pc;
            if (access_op <= c6502lsu_pkg::OP_LDY) begin
                res.kind = c6502lsu_pkg::KIND_READ;
            end else begin
                res.kind = c6502lsu_pkg::KIND_WRITE;
                case (access_op)
                    c6502lsu_pkg::OP_STA: res.write_data = acc_reg;
                    c6502lsu_pkg::OP_STX: res.write_data = x_reg;
                    default:              res.write_data = y_reg;
                endcase
            end
        end

        if (do_load) begin
            flags_next = c6502lsu_pkg::nz_update(flags_reg, load_val);
            case (load_op)
                c6502lsu_pkg::OP_LDA: acc_next = load_val;
                c6502lsu_pkg::OP_LDX: x_next   = load_val;
                default:              y_next   = load_val;
            endcase
        end

        res.acc_value   = acc_next;
        res.x_value     = x_next;
        res.y_value     = y_next;
        res.stack_value = sp_next;
        res.status_byte = c6502lsu_pkg::status_pack(flags_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= 8'h00;
            x_reg         <= 8'h00;
            y_reg         <= 8'h00;
            sp_reg        <= c6502lsu_pkg::SP_RESET;
            flags_reg     <= 6'h00;
            phase_reg     <= c6502lsu_pkg::PH_IDLE;
            pend_op_reg   <= c6502lsu_pkg::OP_LDA;
            pend_mode_reg <= c6502lsu_pkg::MODE_IMP;
            ptr_low_reg   <= 8'h00;
            zp_ptr_reg    <= 8'h00;
        end else begin
            acc_reg       <= acc_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            sp_reg        <= sp_next;
            flags_reg     <= flags_next;
            phase_reg     <= phase_next;
            pend_op_reg   <= pend_op_next;
            pend_mode_reg <= pend_mode_next;
            ptr_low_reg   <= ptr_low_next;
            zp_ptr_reg    <= zp_ptr_next;
        end
    end

    // result buffer: output register plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (accept) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {7'h00, out_reg.page_crossed, out_reg.status_byte,
                       out_reg.stack_value, out_reg.y_value, out_reg.x_value,
                       out_reg.acc_value, out_reg.write_data, out_reg.bus_addr};

    assign phase_idle = (phase_reg == c6502lsu_pkg::PH_IDLE);
    assign data_back  = accept && in_cmd && (phase_reg == c6502lsu_pkg::PH_DATA);
    assign err_out    = out_valid_reg && (out_reg.kind == c6502lsu_pkg::KIND_ERR);

    `C6502_ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_reg || out_valid_reg, "skid without output")
    `C6502_ASSERT_NEXT(a_data_ends_idle, data_back, phase_idle, "load data not done")
    `C6502_ASSERT_ALWAYS(a_err_no_cross, !(err_out && out_reg.page_crossed), "crossing on error")

endmodule

`default_nettype wire
